FILE: hw/rtl/seven_segment_mux_driver_top_assert.svh
// Assertion macros used by the display driver checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SEVEN_SEGMENT_MUX_DRIVER_TOP_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_DRIVER_TOP_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define SSMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SSMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ssmd_pkg.sv
// Shared types, constants and the font function of the seven-segment driver.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package ssmd_pkg;

   localparam int MAX_DIGITS = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int COUNT_W = 4;

   localparam logic [7:0] DOT_PATTERN = 8'h7F;
   localparam logic [7:0] DP_CLEAR = 8'h7F;
   localparam logic [3:0] DEFAULT_COUNT = 4'd4;

   typedef struct packed {
      logic       is_char;
      logic [7:0] font;
      logic       restart;
      logic [7:0] dot_mask;
   } item_type;

   localparam logic [7:0] GLYPHS [128] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hDD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hDF,
      8'hC6, 8'hF0, 8'h9C, 8'hFF, 8'h7F, 8'hBF, 8'h7F, 8'hFF,
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'hFF, 8'hFF, 8'hFF, 8'hB7, 8'hFF, 8'hAC,
      8'hFF, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2,
      8'h89, 8'hCF, 8'hE1, 8'hFF, 8'hC7, 8'hC8, 8'hAB, 8'hC0,
      8'h8C, 8'hFF, 8'hAF, 8'h92, 8'h87, 8'hC1, 8'hFF, 8'hFF,
      8'hFF, 8'h91, 8'hFF, 8'hC6, 8'hFF, 8'hF0, 8'hFF, 8'hF7,
      8'hFF, 8'h88, 8'h83, 8'hA7, 8'hA1, 8'h86, 8'h8E, 8'hC2,
      8'h8B, 8'hEF, 8'hF1, 8'hFF, 8'hF9, 8'hFF, 8'hAB, 8'hA3,
      8'h8C, 8'hFF, 8'hAF, 8'h92, 8'h87, 8'hE3, 8'hFF, 8'hFF,
      8'hFF, 8'h91, 8'hFF, 8'hC6, 8'hF9, 8'hF0, 8'hBF, 8'hFF
   };

   // Upper half of the code space is the raw code with the low seven bits flipped.
   function automatic logic [7:0] font_lookup(input logic [7:0] code);
      logic [7:0] result;
      if (code[7]) begin
         result = code ^ 8'h7F;
      end else begin
         result = GLYPHS[code[6:0]];
      end
      return result;
   endfunction

endpackage

FILE: hw/rtl/ssmd_front.sv
// Request decoder: unpacks a request and maps its code through the font.
// Depends on ssmd_pkg.
`timescale 1ns / 1ps

module ssmd_front (
   input  logic [ssmd_pkg::REQ_DATA_W-1:0] req_data,
   input  logic                            req_kind,
   output ssmd_pkg::item_type              item
);

   always_comb begin
      item.is_char  = req_kind;
      item.font     = ssmd_pkg::font_lookup(req_data[7:0]);
      item.restart  = req_data[8];
      item.dot_mask = req_data[16:9];
   end

endmodule

FILE: hw/rtl/ssmd_queue.sv
// Short queue of decoded requests between the decoder and the display engine.
// Depends on ssmd_pkg.
`timescale 1ns / 1ps

module ssmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssmd_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output ssmd_pkg::item_type head
);

   localparam int PTR_W = (ssmd_pkg::QUEUE_DEPTH > 1) ? $clog2(ssmd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ssmd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(ssmd_pkg::QUEUE_DEPTH - 1);

   ssmd_pkg::item_type storage [ssmd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(ssmd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = storage[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         storage[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/ssmd_back.sv
// Display engine: digit pattern store, write position, scan index and result register.
// Depends on ssmd_pkg.
`timescale 1ns / 1ps

module ssmd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  ssmd_pkg::item_type              item,
   output logic                            item_pop,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssmd_pkg::COUNT_W-1:0]    csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ssmd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (ssmd_pkg::MAX_DIGITS > 1) ? $clog2(ssmd_pkg::MAX_DIGITS) : 1;
   localparam int CW = ssmd_pkg::COUNT_W;

   logic [7:0]     pattern_ff [ssmd_pkg::MAX_DIGITS];
   logic [ssmd_pkg::MAX_DIGITS-1:0] dot_flag_ff, dot_flag_in;
   logic [ssmd_pkg::MAX_DIGITS-1:0] ones_flag_ff, ones_flag_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  wpos_ff, wpos_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [ssmd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CW-1:0]  active;
   logic [CW-1:0]  pos;
   logic [IDX_W-1:0] prev;
   logic           out_free;
   logic           do_char, do_tick, in_range, merge;
   logic           wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]     wr_val;
   logic [7:0]     enables_n;
   logic [CW-1:0]  scan_next;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign item_pop = item_valid && (item.is_char || out_free);
   assign do_char  = item_pop && item.is_char;
   assign do_tick  = item_pop && !item.is_char;

   always_comb begin
      if (count_ff == '0) begin
         active = CW'(1);
      end else if (count_ff > CW'(ssmd_pkg::MAX_DIGITS)) begin
         active = CW'(ssmd_pkg::MAX_DIGITS);
      end else begin
         active = count_ff;
      end
   end

   always_comb begin
      pos      = item.restart ? '0 : wpos_ff;
      prev     = pos[IDX_W-1:0] - IDX_W'(1);
      in_range = (pos < active);
      merge    = in_range && (pos != '0) && (item.font == ssmd_pkg::DOT_PATTERN)
                 && !dot_flag_ff[prev];
      wr_en        = 1'b0;
      wr_idx       = pos[IDX_W-1:0];
      wr_val       = item.font;
      wpos_in      = wpos_ff;
      dot_flag_in  = dot_flag_ff;
      ones_flag_in = ones_flag_ff;
      if (do_char) begin
         if (merge) begin
            wr_en  = 1'b1;
            wr_idx = prev;
            wr_val = pattern_ff[prev] & ssmd_pkg::DP_CLEAR;
            dot_flag_in[prev]  = ones_flag_ff[prev];
            ones_flag_in[prev] = 1'b0;
         end else if (in_range) begin
            wr_en = 1'b1;
            if (item.dot_mask[pos[IDX_W-1:0]]) begin
               wr_val = item.font & ssmd_pkg::DP_CLEAR;
            end
            dot_flag_in[pos[IDX_W-1:0]]  = (wr_val == ssmd_pkg::DOT_PATTERN);
            ones_flag_in[pos[IDX_W-1:0]] = (wr_val == 8'hFF);
            wpos_in = pos + CW'(1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         enables_n[i] = !((IDX_W'(i) == scan_ff) && (i < ssmd_pkg::MAX_DIGITS))
                        || !(CW'(i) < active);
      end
      scan_next    = CW'(scan_ff) + CW'(1);
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (do_tick) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {pattern_ff[scan_ff], enables_n};
         scan_in      = (scan_next >= active) ? '0 : scan_next[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssmd_pkg::MAX_DIGITS; i++) begin
            pattern_ff[i] <= '0;
         end
         dot_flag_ff  <= '0;
         ones_flag_ff <= '0;
         count_ff     <= ssmd_pkg::DEFAULT_COUNT;
         wpos_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            pattern_ff[wr_idx] <= wr_val;
         end
         if (csr_valid) begin
            count_ff <= csr_data;
         end
         dot_flag_ff  <= dot_flag_in;
         ones_flag_ff <= ones_flag_in;
         wpos_ff      <= wpos_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hw/rtl/seven_segment_mux_driver_top.sv
// Seven-segment multiplexed display driver: one request per clock cycle when
// the result side keeps up. A character request is decoded through the font
// on entry and updates the digit store at the edge at which it leaves the
// two-entry queue; a scan tick loads the result register at the edge at which
// it leaves the queue, and its result is offered from that register.
// Only ticks wait on the result register, so requests are accepted every cycle
// until the queue fills behind an unread result. Depends on ssmd_pkg,
// ssmd_front, ssmd_queue and ssmd_back.
`timescale 1ns / 1ps

module seven_segment_mux_driver_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_code[7:0], restart[8], dot_mask[16:9], zero fill above.
   input  logic [ssmd_pkg::REQ_DATA_W-1:0] req_tdata,
   // func: 0 for a scan tick, 1 for a character write.
   input  logic                            req_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssmd_pkg::COUNT_W-1:0]    csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // digit_enables_n[7:0], segments_n[15:8].
   output logic [ssmd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   ssmd_pkg::item_type dec_item;
   ssmd_pkg::item_type head_item;
   logic q_full, q_not_empty, q_pop;

   assign req_tready = !q_full;

   ssmd_front u_front (
      .req_data (req_tdata),
      .req_kind (req_tuser),
      .item     (dec_item)
   );

   ssmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !q_full),
      .push_item (dec_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_item)
   );

   ssmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (head_item),
      .item_pop   (q_pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hw/rtl/ssmd_checker.sv
// Port-level checker for the display driver, bound to the top level.
// Depends on ssmd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "seven_segment_mux_driver_top_assert.svh"

module ssmd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ssmd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   `SSMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `SSMD_ASSERT_NOW(a_one_digit, clock, reset, rsp_tvalid, $countones(~rsp_tdata[7:0]) <= 1, "more than one digit enabled")
   `SSMD_ASSERT_NOW(a_full_needs_stall, clock, reset, !req_tready, rsp_tvalid, "queue full without a pending result")

endmodule

bind seven_segment_mux_driver_top ssmd_checker u_ssmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/display_scoreboard.sv
// Scoreboard for the seven-segment display driver: predicts every scan result and checks it.
// It watches the request, result and register channels of the block.
// Depends on ssmd_pkg for the channel widths and the reset digit count.
`timescale 1ns / 1ps

module display_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ssmd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [ssmd_pkg::COUNT_W-1:0]    csr_data,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ssmd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              error_count,
   output int                              pending
);

   typedef struct packed {
      logic [7:0] segments_n;
      logic [7:0] enables_n;
   } scan_result_type;

   localparam logic [7:0] DOT_GLYPH = 8'h7F;
   localparam int DIGIT_SLOTS = 8;

   // Font for the lower half of the code space, code 0 in the top byte.
   localparam logic [1023:0] GLYPH_BITS = {
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hDD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hDF,
      8'hC6, 8'hF0, 8'h9C, 8'hFF, 8'h7F, 8'hBF, 8'h7F, 8'hFF,
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'hFF, 8'hFF, 8'hFF, 8'hB7, 8'hFF, 8'hAC,
      8'hFF, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hC2,
      8'h89, 8'hCF, 8'hE1, 8'hFF, 8'hC7, 8'hC8, 8'hAB, 8'hC0,
      8'h8C, 8'hFF, 8'hAF, 8'h92, 8'h87, 8'hC1, 8'hFF, 8'hFF,
      8'hFF, 8'h91, 8'hFF, 8'hC6, 8'hFF, 8'hF0, 8'hFF, 8'hF7,
      8'hFF, 8'h88, 8'h83, 8'hA7, 8'hA1, 8'h86, 8'h8E, 8'hC2,
      8'h8B, 8'hEF, 8'hF1, 8'hFF, 8'hF9, 8'hFF, 8'hAB, 8'hA3,
      8'h8C, 8'hFF, 8'hAF, 8'h92, 8'h87, 8'hE3, 8'hFF, 8'hFF,
      8'hFF, 8'h91, 8'hFF, 8'hC6, 8'hF9, 8'hF0, 8'hBF, 8'hFF
   };

   logic [3:0]   digit_count;
   logic [7:0]   digit_store [DIGIT_SLOTS];
   logic [3:0]   write_pos;
   logic [2:0]   scan_pos;
   scan_result_type expected_scans [$];

   function automatic logic [7:0] glyph_of(input logic [7:0] code);
      int idx;
      idx = 127 - int'(code[6:0]);
      if (code[7]) begin
         return code ^ 8'h7F;
      end
      return GLYPH_BITS[idx * 8 +: 8];
   endfunction

   function automatic int digits_in_use();
      int n;
      n = int'(digit_count);
      if (n < 1) begin
         n = 1;
      end
      if (n > DIGIT_SLOTS) begin
         n = DIGIT_SLOTS;
      end
      return n;
   endfunction

   task automatic write_char(input logic [7:0] code, input logic restart,
                             input logic [7:0] mask);
      logic [7:0] pattern;
      int n;
      int p;
      n = digits_in_use();
      pattern = glyph_of(code);
      if (restart) begin
         write_pos = 4'd0;
      end
      p = int'(write_pos);
      if (p >= n) begin
         return;
      end
      // A dot after a non-dot digit lights the previous decimal point in place.
      if (p > 0 && pattern == DOT_GLYPH && digit_store[p - 1] != DOT_GLYPH) begin
         digit_store[p - 1][7] = 1'b0;
         return;
      end
      if (mask[p]) begin
         pattern[7] = 1'b0;
      end
      digit_store[p] = pattern;
      write_pos = 4'(p + 1);
   endtask

   task automatic scan_tick(output scan_result_type result);
      int n;
      int s;
      logic [8:0] used;
      logic [7:0] select;
      n = digits_in_use();
      s = int'(scan_pos);
      used = 9'((1 << n) - 1);
      select = 8'(1 << s);
      result.enables_n = ~select | ~used[7:0];
      result.segments_n = digit_store[s];
      s = s + 1;
      if (s >= n) begin
         s = 0;
      end
      scan_pos = 3'(s);
   endtask

   initial begin
      error_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin : monitor
      scan_result_type got;
      scan_result_type want;
      if (reset) begin
         digit_count = ssmd_pkg::DEFAULT_COUNT;
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            digit_store[i] = 8'h00;
         end
         write_pos = 4'd0;
         scan_pos = 3'd0;
         expected_scans.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            digit_count = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_scans.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
               error_count++;
            end else begin
               want = expected_scans.pop_front();
               if (got.enables_n !== want.enables_n) begin
                  $display("%0t: digit_enables_n mismatch, expected %h, actual %h",
                           $realtime, want.enables_n, got.enables_n);
                  error_count++;
               end
               if (got.segments_n !== want.segments_n) begin
                  $display("%0t: segments_n mismatch, expected %h, actual %h",
                           $realtime, want.segments_n, got.segments_n);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               write_char(req_tdata[7:0], req_tdata[8], req_tdata[16:9]);
            end else begin
               scan_tick(want);
               expected_scans.push_back(want);
            end
         end
      end
      pending = expected_scans.size();
   end

endmodule

FILE: tb/tb_top.sv
// Top of the display driver testbench: clock, reset, request and register stimulus, verdict.
// Instantiates seven_segment_mux_driver_top and display_scoreboard; depends on ssmd_pkg.
`timescale 1ns / 1ps

module tb_top;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_CHAR = 1'b1;
   localparam logic [7:0] CODE_COMMA = 8'h2C;
   localparam logic [7:0] CODE_DOT = 8'h2E;
   localparam logic [7:0] CODE_BLANK = 8'h10;
   localparam logic [7:0] CODE_ZERO_CHAR = 8'h30;
   localparam int SETTLE_CYCLES = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES = 14;
   localparam int PHASE_ITEMS = 126;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [ssmd_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [ssmd_pkg::COUNT_W-1:0]    csr_data;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [ssmd_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int error_count;
   int pending;
   int rsp_gap;
   bit rsp_taken;
   int idle_cycles;
   int chars_sent;
   int ticks_sent;
   int csr_writes;
   bit calm;

   seven_segment_mux_driver_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   display_scoreboard scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #1 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      rsp_taken <= rsp_tvalid && rsp_tready;
   end

   always @(negedge clock) begin : rsp_pacer
      int draw;
      draw = rsp_gap;
      if (reset) begin
         draw = 0;
      end else if (rsp_taken) begin
         draw = calm ? 0 : int'($urandom_range(0, 10));
      end
      if (draw > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap <= draw - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap <= 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(input logic func, input logic [7:0] code,
                               input logic restart, input logic [7:0] mask);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      for (int i = 0; i < gap; i++) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {7'd0, mask, restart, code};
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
      if (func == FUNC_CHAR) begin
         chars_sent++;
      end else begin
         ticks_sent++;
      end
   endtask

   task automatic send_tick();
      send_request(FUNC_TICK, 8'($urandom), 1'($urandom), 8'($urandom));
   endtask

   task automatic send_char(input logic [7:0] code, input logic restart,
                            input logic [7:0] mask);
      send_request(FUNC_CHAR, code, restart, mask);
   endtask

   // Holds requests back until every scan result is in and the store has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_digit_count(input logic [3:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   function automatic logic [7:0] pick_char_code();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         return ($urandom_range(0, 1) == 0) ? CODE_DOT : CODE_COMMA;
      end else if (roll < 55) begin
         return CODE_ZERO_CHAR + 8'($urandom_range(0, 9));
      end else if (roll < 70) begin
         return 8'($urandom_range(0, 15));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [3:0] count_plan [PHASES];
      logic [7:0] mask;
      count_plan = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd8, 4'd5, 4'd3, 4'd7, 4'd6,
                     4'd9, 4'd4, 4'd8, 4'd1};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_TICK;
      csr_valid = 1'b0;
      csr_data = '0;
      idle_cycles = 0;
      chars_sent = 0;
      ticks_sent = 0;
      csr_writes = 0;
      calm = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests, first at the reset digit count, then at counts eight and two.
      send_tick();
      send_char(CODE_ZERO_CHAR + 8'd8, 1'b1, 8'h00);
      send_char(CODE_DOT, 1'b0, 8'h00);
      send_char(CODE_DOT, 1'b0, 8'h00);
      send_char(8'hFF, 1'b0, 8'hFF);
      send_char(8'h80, 1'b0, 8'h00);
      send_char(8'h00, 1'b0, 8'h00);
      send_char(8'h7A, 1'b0, 8'hFF);
      repeat (4) send_tick();
      send_char(CODE_DOT, 1'b1, 8'h00);
      send_char(CODE_COMMA, 1'b0, 8'h00);
      send_char(CODE_BLANK, 1'b0, 8'h00);
      send_char(CODE_DOT, 1'b0, 8'h00);
      send_char(CODE_DOT, 1'b0, 8'h00);
      repeat (4) send_tick();
      write_digit_count(4'd8);
      for (int i = 0; i < 8; i++) begin
         send_char(CODE_ZERO_CHAR + 8'(i), (i == 0), 8'hAA);
      end
      repeat (3) send_tick();
      write_digit_count(4'd2);
      repeat (2) send_tick();

      for (int phase = 0; phase < PHASES; phase++) begin
         write_digit_count((phase < 12) ? count_plan[phase] : 4'($urandom_range(0, 15)));
         calm = (phase % 4 == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 40) begin
               send_tick();
            end else begin
               mask = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
               send_char(pick_char_code(), ($urandom_range(0, 4) == 0), mask);
            end
         end
      end

      calm = 1'b0;
      drain();
      $display("Sent %0d character writes and %0d scan ticks over %0d digit count settings,",
               chars_sent, ticks_sent, csr_writes);
      $display("with dots, restarts, overflow writes and shrinking scan ranges mixed in.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ssmd_pkg.sv
hw/rtl/ssmd_front.sv
hw/rtl/ssmd_queue.sv
hw/rtl/ssmd_back.sv
hw/rtl/seven_segment_mux_driver_top.sv
hw/rtl/ssmd_checker.sv
tb/display_scoreboard.sv
tb/tb_top.sv
